// ----- rtl/core/plwq_pkg.sv -----
package plwq_pkg;

   // Pool and level counts; handle and level widths follow from them.
   localparam int POOL_SIZE = 64;
   localparam int LEVELS    = 4;
   localparam int HANDLE_W  = $clog2(POOL_SIZE);
   localparam int LINK_W    = HANDLE_W + 1;
   localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // Fixed widths of the transaction fields.
   localparam int CMD_FIELD_W    = 3;
   localparam int PRIO_FIELD_W   = 2;
   localparam int HANDLE_FIELD_W = 6;

   // A link that names no handle.
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SIZE);

   typedef enum logic [CMD_FIELD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PUSH   = 3'd1,
      CMD_POP    = 3'd2,
      CMD_CHECK  = 3'd3,
      CMD_REMOVE = 3'd4
   } cmd_type;

   // Backward link and level of a handle share one memory word.
   typedef struct packed {
      logic [LEVEL_W-1:0] lvl;
      logic [LINK_W-1:0]  prev;
   } prev_entry_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] rd_addr;
      logic                next_we;
      logic [HANDLE_W-1:0] next_addr;
      logic [LINK_W-1:0]   next_data;
      logic                prev_we;
      logic [HANDLE_W-1:0] prev_addr;
      prev_entry_type      prev_data;
   } link_req_type;

   typedef struct packed {
      logic [LINK_W-1:0] next;
      prev_entry_type    prev_entry;
   } link_rd_type;

   typedef struct packed {
      logic [PRIO_FIELD_W-1:0]   prio;
      logic [HANDLE_FIELD_W-1:0] handle;
      logic                      ok;
   } res_type;

   function automatic logic link_valid(input logic [LINK_W-1:0] link);
      return link < LINK_NONE;
   endfunction

endpackage

// ----- rtl/core/plwq_link_store.sv -----
module plwq_link_store (
   input  logic                  clock,
   input  plwq_pkg::link_req_type req,
   output plwq_pkg::link_rd_type  rd
);
   import plwq_pkg::*;

   logic [LINK_W-1:0] next_mem [POOL_SIZE];
   prev_entry_type    prev_mem [POOL_SIZE];
   link_rd_type       rd_ff;

   // Both memories are read at one shared address; the read data is registered.
   always_ff @(posedge clock) begin
      if (req.next_we) begin
         next_mem[req.next_addr] <= req.next_data;
      end
      if (req.prev_we) begin
         prev_mem[req.prev_addr] <= req.prev_data;
      end
      rd_ff.next       <= next_mem[req.rd_addr];
      rd_ff.prev_entry <= prev_mem[req.rd_addr];
   end

   assign rd = rd_ff;

endmodule

// ----- rtl/core/plwq_ctrl.sv -----
module plwq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [plwq_pkg::CMD_FIELD_W-1:0]     req_cmd,
   input  logic [plwq_pkg::PRIO_FIELD_W-1:0]    req_prio,
   input  logic [plwq_pkg::HANDLE_FIELD_W-1:0]  req_handle,
   output logic                                 res_valid,
   input  logic                                 res_taken,
   output plwq_pkg::res_type                    res,
   output plwq_pkg::link_req_type               link_req,
   input  plwq_pkg::link_rd_type                link_rd
);
   import plwq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LINK,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [LEVEL_W-1:0]    prio_ff, prio_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic                  arg_ok_ff, arg_ok_in;
   logic [LINK_W-1:0]     tail_save_ff, tail_save_in;
   logic [LINK_W-1:0]     head_ff [LEVELS];
   logic [LINK_W-1:0]     head_in [LEVELS];
   logic [LINK_W-1:0]     tail_ff [LEVELS];
   logic [LINK_W-1:0]     tail_in [LEVELS];
   logic [POOL_SIZE-1:0]  queued_ff, queued_in;
   res_type               res_ff, res_in;

   logic                  any_wait;
   logic [LEVEL_W-1:0]    first_lvl;

   // Lowest-numbered level that holds a handle.
   always_comb begin
      any_wait  = 1'b0;
      first_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (link_valid(head_ff[i])) begin
            any_wait  = 1'b1;
            first_lvl = LEVEL_W'(i);
         end
      end
   end

   always_comb begin
      logic                do_unlink;
      logic [LEVEL_W-1:0]  u_lvl;
      logic [LINK_W-1:0]   u_prev;
      logic [LINK_W-1:0]   u_next;
      logic [LINK_W-1:0]   t;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      prio_in      = prio_ff;
      handle_in    = handle_ff;
      arg_ok_in    = arg_ok_ff;
      tail_save_in = tail_save_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      queued_in    = queued_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      do_unlink    = 1'b0;
      t            = tail_ff[prio_ff];

      link_req = '0;
      if (cmd_type'(req_cmd) == CMD_POP) begin
         link_req.rd_addr = head_ff[first_lvl][HANDLE_W-1:0];
      end else begin
         link_req.rd_addr = HANDLE_W'(req_handle);
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               arg_ok_in = (int'(req_handle) < POOL_SIZE) && (int'(req_prio) < LEVELS);
               if (cmd_type'(req_cmd) == CMD_POP) begin
                  handle_in = head_ff[first_lvl][HANDLE_W-1:0];
                  prio_in   = first_lvl;
               end else begin
                  handle_in = HANDLE_W'(req_handle);
                  prio_in   = LEVEL_W'(req_prio);
               end
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_RESP;
            case (cmd_ff)
               CMD_CLEAR: begin
                  for (int i = 0; i < LEVELS; i++) begin
                     head_in[i] = LINK_NONE;
                     tail_in[i] = LINK_NONE;
                  end
                  queued_in = '0;
                  res_in.ok = 1'b1;
               end
               CMD_PUSH: begin
                  if (arg_ok_ff && !queued_ff[handle_ff]) begin
                     link_req.prev_we        = 1'b1;
                     link_req.prev_addr      = handle_ff;
                     link_req.prev_data.prev = t;
                     link_req.prev_data.lvl  = prio_ff;
                     link_req.next_we        = 1'b1;
                     link_req.next_addr      = handle_ff;
                     link_req.next_data      = LINK_NONE;
                     tail_in[prio_ff]        = LINK_W'(handle_ff);
                     queued_in[handle_ff]    = 1'b1;
                     if (link_valid(t)) begin
                        // The old tail's forward link is written next cycle.
                        tail_save_in = t;
                        state_in     = ST_LINK;
                     end else begin
                        head_in[prio_ff] = LINK_W'(handle_ff);
                     end
                     res_in.ok = 1'b1;
                  end
               end
               CMD_POP: begin
                  if (any_wait) begin
                     do_unlink     = 1'b1;
                     res_in.ok     = 1'b1;
                     res_in.handle = HANDLE_FIELD_W'(handle_ff);
                     res_in.prio   = PRIO_FIELD_W'(prio_ff);
                  end
               end
               CMD_CHECK: begin
                  res_in.ok = any_wait;
               end
               CMD_REMOVE: begin
                  if (arg_ok_ff && queued_ff[handle_ff]) begin
                     do_unlink = 1'b1;
                     res_in.ok = 1'b1;
                  end
               end
               default: begin
                  res_in.ok = 1'b0;
               end
            endcase
         end

         ST_LINK: begin
            link_req.next_we   = 1'b1;
            link_req.next_addr = tail_save_ff[HANDLE_W-1:0];
            link_req.next_data = LINK_W'(handle_ff);
            state_in           = ST_RESP;
         end

         ST_RESP: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Unlink the handle whose links were read at acceptance. Its neighbors sit
      // in the same level, so the level of the next handle is rewritten unchanged.
      u_lvl  = link_rd.prev_entry.lvl;
      u_prev = link_rd.prev_entry.prev;
      u_next = link_rd.next;
      if (int'(u_lvl) >= LEVELS) begin
         u_lvl = '0;
      end
      if (do_unlink) begin
         if (link_valid(u_prev)) begin
            link_req.next_we   = 1'b1;
            link_req.next_addr = u_prev[HANDLE_W-1:0];
            link_req.next_data = u_next;
         end else begin
            head_in[u_lvl] = u_next;
         end
         if (link_valid(u_next)) begin
            link_req.prev_we        = 1'b1;
            link_req.prev_addr      = u_next[HANDLE_W-1:0];
            link_req.prev_data.prev = u_prev;
            link_req.prev_data.lvl  = u_lvl;
         end else begin
            tail_in[u_lvl] = u_prev;
         end
         queued_in[handle_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      prio_ff      <= prio_in;
      handle_ff    <= handle_in;
      arg_ok_ff    <= arg_ok_in;
      tail_save_ff <= tail_save_in;
      res_ff       <= res_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         queued_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= LINK_NONE;
            tail_ff[i] <= LINK_NONE;
         end
      end else begin
         state_ff  <= state_in;
         queued_ff <= queued_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/priority_linked_wait_queue_top.sv -----
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     cmd, prio, handle in req_tdata
// rsp_      out        rsp_tvalid/tready     ok, out_handle, out_prio in rsp_tdata
//
// One transaction at a time: after acceptance the controller passes EXEC, then RESP,
// before the output register loads; a push onto a non-empty level passes LINK between
// them, since its second forward-link write needs the single write port of that memory.
// Reset is synchronous and active high; it empties every level at once.
// A new request is taken while a finished response still waits in the output
// register; a stalled response holds the following one in the controller.
module priority_linked_wait_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd [2:0], prio [4:3], handle [10:5], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // ok [0], out_handle [6:1], out_prio [8:7], zero fill
);
   import plwq_pkg::*;

   link_req_type link_req;
   link_rd_type  link_rd;
   res_type      res;
   logic         res_valid;
   logic         res_taken;

   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]  rsp_tdata_ff, rsp_tdata_in;

   // The controller keeps head, tail and queued flags in flip-flops and does the
   // list surgery; the link store holds the forward and backward links.
   plwq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tdata[2:0]),
      .req_prio   (req_tdata[4:3]),
      .req_handle (req_tdata[10:5]),
      .res_valid  (res_valid),
      .res_taken  (res_taken),
      .res        (res),
      .link_req   (link_req),
      .link_rd    (link_rd)
   );

   plwq_link_store u_link_store (
      .clock (clock),
      .req   (link_req),
      .rd    (link_rd)
   );

   // The output register loads a waiting response whenever it is empty or being drained.
   assign res_taken = res_valid && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (res_taken) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {7'd0, res};
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ----- dv/priority_linked_wait_queue_top_test.sv -----
`timescale 1ns / 1ps

module priority_linked_wait_queue_top_test;

   import plwq_pkg::*;

   // Command codes five to seven carry no operation. The block must answer them
   // with a plain "not ok" response and leave every list untouched.
   localparam logic [CMD_FIELD_W-1:0] CMD_SPARE_FIRST = CMD_FIELD_W'(5);
   localparam logic [CMD_FIELD_W-1:0] CMD_SPARE_LAST  = CMD_FIELD_W'(7);

   // The slowest legal run is about 2000 transactions, each held up by the
   // longest sender gap and the longest response stall. The limit below leaves
   // a wide margin over that worst case.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 40;

   typedef logic [CMD_FIELD_W-1:0]    cmd_code_type;
   typedef logic [PRIO_FIELD_W-1:0]   prio_field_type;
   typedef logic [HANDLE_FIELD_W-1:0] handle_field_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // cmd [2:0], prio [4:3], handle [10:5], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // ok [0], out_handle [6:1], out_prio [8:7], zero fill

   priority_linked_wait_queue_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The clock period is 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // This is a shadow copy of the wait lists. It is updated once for each
   // request transaction that the block accepts.
   logic [LINK_W-1:0]  lvl_head   [LEVELS];
   logic [LINK_W-1:0]  lvl_tail   [LEVELS];
   logic [LINK_W-1:0]  fwd_link   [POOL_SIZE];
   logic [LINK_W-1:0]  back_link  [POOL_SIZE];
   logic               is_waiting [POOL_SIZE];
   logic [LEVEL_W-1:0] home_level [POOL_SIZE];
   int                 waiting_count;
   int                 peak_waiting;

   // Responses that the lists predict are held here until the block returns them.
   res_type expected_replies[$];

   int  error_count  = 0;
   int  report_count = 0;
   int  cycle_count  = 0;
   int  sent_count   = 0;
   int  ok_by_cmd [8];
   bit  gaps_on      = 1'b0;
   int  stall_left   = 0;

   // Most gaps are zero or a few cycles long. A few gaps are long, so that
   // stalls land on every phase of the block's multi-cycle link updates.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55)
         return 0;
      else if (roll < 88)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic void empty_levels();
      int i;
      for (i = 0; i < LEVELS; i++) begin
         lvl_head[i] = LINK_NONE;
         lvl_tail[i] = LINK_NONE;
      end
      for (i = 0; i < POOL_SIZE; i++)
         is_waiting[i] = 1'b0;
      waiting_count = 0;
   endfunction

   // Splice a waiting handle out of its level. Its neighbors are joined
   // together. Where the handle has no neighbor on a side, the head or the
   // tail of the level moves instead.
   function automatic void unlink_entry(input handle_field_type h);
      logic [LEVEL_W-1:0] lvl;
      logic [LINK_W-1:0]  p;
      logic [LINK_W-1:0]  n;
      lvl = home_level[h];
      p   = back_link[h];
      n   = fwd_link[h];
      if (p != LINK_NONE)
         fwd_link[p[HANDLE_W-1:0]] = n;
      else
         lvl_head[lvl] = n;
      if (n != LINK_NONE)
         back_link[n[HANDLE_W-1:0]] = p;
      else
         lvl_tail[lvl] = p;
      is_waiting[h] = 1'b0;
      waiting_count--;
   endfunction

   // This applies one command to the shadow lists and returns the response
   // that the block must produce for it.
   function automatic res_type serve_command(input cmd_code_type code,
                                             input prio_field_type lvl,
                                             input handle_field_type h);
      res_type           reply;
      logic [LINK_W-1:0] t;
      bit                found;
      int                i;
      reply = '0;
      found = 1'b0;
      case (code)
         CMD_CLEAR: begin
            empty_levels();
            reply.ok = 1'b1;
         end
         CMD_PUSH: begin
            if (!is_waiting[h]) begin
               t            = lvl_tail[lvl];
               back_link[h] = t;
               fwd_link[h]  = LINK_NONE;
               if (t != LINK_NONE)
                  fwd_link[t[HANDLE_W-1:0]] = LINK_W'(h);
               else
                  lvl_head[lvl] = LINK_W'(h);
               lvl_tail[lvl]  = LINK_W'(h);
               is_waiting[h]  = 1'b1;
               home_level[h]  = lvl;
               waiting_count++;
               reply.ok = 1'b1;
            end
         end
         CMD_POP: begin
            for (i = 0; i < LEVELS && !found; i++) begin
               if (lvl_head[i] != LINK_NONE) begin
                  reply.handle = lvl_head[i][HANDLE_W-1:0];
                  reply.prio   = PRIO_FIELD_W'(i);
                  reply.ok     = 1'b1;
                  unlink_entry(reply.handle);
                  found = 1'b1;
               end
            end
         end
         CMD_CHECK: begin
            for (i = 0; i < LEVELS; i++)
               if (lvl_head[i] != LINK_NONE)
                  reply.ok = 1'b1;
         end
         CMD_REMOVE: begin
            if (is_waiting[h]) begin
               unlink_entry(h);
               reply.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   // This picks a handle that is waiting (or one that is free, as asked) when
   // there is one. The search starts at a random point in the pool.
   function automatic handle_field_type pick_handle(input bit want_waiting);
      int start;
      int k;
      start = $urandom_range(0, POOL_SIZE - 1);
      for (k = 0; k < POOL_SIZE; k++)
         if (is_waiting[(start + k) % POOL_SIZE] == want_waiting)
            return HANDLE_FIELD_W'((start + k) % POOL_SIZE);
      return HANDLE_FIELD_W'(start);
   endfunction

   task automatic apply_reset();
      int i;
      empty_levels();
      for (i = 0; i < POOL_SIZE; i++) begin
         fwd_link[i]   = '0;
         back_link[i]  = '0;
         home_level[i] = '0;
      end
      for (i = 0; i < 8; i++)
         ok_by_cmd[i] = 0;
      peak_waiting = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   endtask

   // This task presents one request and holds it until the handshake completes.
   // The expected response is recorded at acceptance. After that the task may
   // idle for a while. When no gap follows, valid stays high into the next
   // transaction.
   task automatic send_command(input cmd_code_type code, input prio_field_type lvl,
                               input handle_field_type h);
      res_type reply;
      int      gap;
      req_tdata  <= 16'({h, lvl, code});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      reply = serve_command(code, lvl, h);
      expected_replies.push_back(reply);
      sent_count++;
      if (reply.ok)
         ok_by_cmd[code]++;
      if (waiting_count > peak_waiting)
         peak_waiting = waiting_count;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
   endtask

   // These commands run against an empty queue: a pop with nothing waiting, a
   // check, a remove of a handle that is not queued, every unused code, and
   // a clear.
   task automatic test_empty_queue();
      send_command(CMD_POP, '0, '0);
      send_command(CMD_CHECK, '0, '0);
      send_command(CMD_REMOVE, '0, '1);
      send_command(CMD_SPARE_FIRST, '1, '1);
      send_command(CMD_FIELD_W'(CMD_SPARE_FIRST + 1), '0, '0);
      send_command(CMD_SPARE_LAST, '1, '1);
      send_command(CMD_CLEAR, '1, '1);
   endtask

   // This fills each level with one handle, using the extreme handles and
   // levels. One push repeats a handle that is already queued, and the block
   // must reject it. Pops must then come back in strict level order, and a
   // final pop must find nothing.
   task automatic test_priority_order();
      send_command(CMD_PUSH, 2'd3, '1);
      send_command(CMD_PUSH, 2'd0, '0);
      send_command(CMD_PUSH, 2'd1, 6'd21);
      send_command(CMD_PUSH, 2'd2, 6'd42);
      send_command(CMD_PUSH, 2'd0, '1);
      send_command(CMD_CHECK, '0, '0);
      repeat (5) send_command(CMD_POP, '0, '0);
   endtask

   // These removes target the middle, the tail and the last entry of one
   // level. Then a clear hits a level that still holds a handle.
   task automatic test_unlink_positions();
      send_command(CMD_PUSH, 2'd1, 6'd10);
      send_command(CMD_PUSH, 2'd1, 6'd11);
      send_command(CMD_PUSH, 2'd1, 6'd12);
      send_command(CMD_REMOVE, '0, 6'd11);
      send_command(CMD_REMOVE, '0, 6'd12);
      send_command(CMD_REMOVE, '0, 6'd10);
      send_command(CMD_PUSH, 2'd1, 6'd20);
      send_command(CMD_CLEAR, '0, '0);
      send_command(CMD_CHECK, '0, '0);
   endtask

   // This sends random commands. Most of them are well formed: pushes of free
   // handles, pops and removes of queued ones. The rest are duplicates, misses,
   // checks, clears and unused codes. The share of pushes sets whether the
   // pool tends to fill or to drain.
   task automatic run_random_traffic(input int count, input int push_per_mille);
      int n;
      int roll;
      int share;
      share = (940 - push_per_mille) / 2;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 999);
         if (roll < push_per_mille)
            send_command(CMD_PUSH, prio_field_type'($urandom_range(0, LEVELS - 1)),
                         pick_handle($urandom_range(0, 99) >= 85));
         else if (roll < push_per_mille + share)
            send_command(CMD_POP, prio_field_type'($urandom),
                         handle_field_type'($urandom));
         else if (roll < 940)
            send_command(CMD_REMOVE, prio_field_type'($urandom),
                         pick_handle($urandom_range(0, 99) < 80));
         else if (roll < 970)
            send_command(CMD_CHECK, prio_field_type'($urandom),
                         handle_field_type'($urandom));
         else if (roll < 975)
            send_command(CMD_CLEAR, prio_field_type'($urandom),
                         handle_field_type'($urandom));
         else
            send_command(cmd_code_type'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                         prio_field_type'($urandom), handle_field_type'($urandom));
      end
   endtask

   // Push-heavy traffic without any idling drives the pool up to full. This
   // also exercises rejected pushes once no free handle is left.
   task automatic test_burst_fill();
      gaps_on = 1'b0;
      run_random_traffic(300, 750);
   endtask

   // Pops and removes dominate while both sides idle at random. Afterwards the
   // sender holds back until every outstanding response has come back.
   task automatic test_drain_pressure();
      gaps_on = 1'b1;
      run_random_traffic(300, 200);
      wait_for_replies();
   endtask

   task automatic test_mixed_traffic();
      gaps_on = 1'b1;
      run_random_traffic(1300, 480);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      error_count++;
      if (report_count < MAX_REPORTS)
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      report_count++;
   endtask

   // The response side checks every response transaction against the oldest
   // expectation. The ready signal follows its own random stall pattern.
   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = res_type'(rsp_tdata[$bits(res_type)-1:0]);
            if (expected_replies.size() == 0) begin
               error_count++;
               $error("unexpected response: ok %0d handle %0d prio %0d",
                      got.ok, got.handle, got.prio);
            end else begin
               want = expected_replies.pop_front();
               if (got.ok !== want.ok)
                  report_field("ok", want.ok, got.ok);
               if (got.handle !== want.handle)
                  report_field("out_handle", want.handle, got.handle);
               if (got.prio !== want.prio)
                  report_field("out_prio", want.prio, got.prio);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // This watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_replies.size());
         $display("priority_linked_wait_queue_top_test: errors");
         $finish;
      end
   end

   initial begin
      apply_reset();
      test_empty_queue();
      test_priority_order();
      test_unlink_positions();
      test_burst_fill();
      test_drain_pressure();
      test_mixed_traffic();
      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d commands: %0d pushes linked, %0d pops served,",
               sent_count, ok_by_cmd[CMD_PUSH], ok_by_cmd[CMD_POP]);
      $display("%0d removes unlinked, %0d clears; at most %0d of %0d handles queued at once.",
               ok_by_cmd[CMD_REMOVE], ok_by_cmd[CMD_CLEAR], peak_waiting, POOL_SIZE);
      if (error_count == 0)
         $display("priority_linked_wait_queue_top_test: clean");
      else
         $display("priority_linked_wait_queue_top_test: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/plwq_pkg.sv
rtl/core/plwq_link_store.sv
rtl/core/plwq_ctrl.sv
rtl/core/priority_linked_wait_queue_top.sv
dv/priority_linked_wait_queue_top_test.sv
